### src/ltl_pkg.sv
// Shared types, character constants and queue geometry for the streaming S-expression lexer.
package ltl_pkg;

  // Input item: one text byte or an end-of-text mark
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } ltl_in_t;

  // Result item: one piece of a token
  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] token_byte;
    logic       byte_valid;
    logic       token_last;
  } ltl_out_t;

  // Lexer modes
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_SYMBOL  = 3'd4,
    MODE_TILDE   = 3'd5
  } ltl_mode_t;

  // Token kinds
  typedef enum logic [3:0] {
    KIND_AMP     = 4'd0,
    KIND_QUOTE   = 4'd1,
    KIND_UNQUOTE = 4'd2,
    KIND_SPLICE  = 4'd3,
    KIND_OPEN    = 4'd4,
    KIND_CLOSE   = 4'd5,
    KIND_NUMBER  = 4'd6,
    KIND_STRING  = 4'd7,
    KIND_SYMBOL  = 4'd8,
    KIND_BADSTR  = 4'd9
  } ltl_kind_t;

  // Result of lexing one item: up to two results and the next mode
  typedef struct packed {
    logic [1:0] num_res;
    ltl_out_t   res0;
    ltl_out_t   res1;
    ltl_mode_t  mode_nxt;
  } ltl_step_t;

  // Character codes
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LBR    = 8'h5B;
  localparam logic [7:0] CH_RBR    = 8'h5D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Result queue geometry
  localparam int SkidDepth = 4;
  localparam int SkidAw    = $clog2(SkidDepth);
  localparam int SkidCw    = $clog2(SkidDepth + 1);

endpackage

### src/ltl_core.sv
// Combinational lexer step: mode and one input item to results and next mode.
module ltl_core
  import ltl_pkg::*;
(
  input  ltl_mode_t mode,
  input  ltl_in_t   item,
  output ltl_step_t step
);

  typedef struct packed {
    logic      hit;
    ltl_out_t  tok;
    ltl_mode_t mode;
  } ltl_idle_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_NUL);
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_DOT);
  endfunction

  function automatic ltl_out_t mk(input ltl_kind_t k, input logic [7:0] c,
                                  input logic v, input logic l);
    ltl_out_t o;
    o.token_kind = k;
    o.token_byte = v ? c : 8'h00;
    o.byte_valid = v;
    o.token_last = l;
    return o;
  endfunction

  // Lex one byte as the start of a new token
  function automatic ltl_idle_t from_idle(input logic [7:0] c);
    ltl_idle_t r;
    r.hit  = 1'b0;
    r.tok  = '0;
    r.mode = MODE_IDLE;
    if (!is_space(c)) begin
      case (c)
        CH_SEMI:   r.mode = MODE_COMMENT;
        CH_TILDE:  r.mode = MODE_TILDE;
        CH_DQUOTE: r.mode = MODE_STRING;
        CH_AMP: begin
          r.hit = 1'b1;
          r.tok = mk(KIND_AMP, c, 1'b1, 1'b1);
        end
        CH_QUOTE: begin
          r.hit = 1'b1;
          r.tok = mk(KIND_QUOTE, c, 1'b1, 1'b1);
        end
        CH_LBR: begin
          r.hit = 1'b1;
          r.tok = mk(KIND_OPEN, c, 1'b1, 1'b1);
        end
        CH_RBR: begin
          r.hit = 1'b1;
          r.tok = mk(KIND_CLOSE, c, 1'b1, 1'b1);
        end
        default: begin
          r.hit = 1'b1;
          if (is_num(c)) begin
            r.mode = MODE_NUMBER;
            r.tok  = mk(KIND_NUMBER, c, 1'b1, 1'b0);
          end else begin
            r.mode = MODE_SYMBOL;
            r.tok  = mk(KIND_SYMBOL, c, 1'b1, 1'b0);
          end
        end
      endcase
    end
    return r;
  endfunction

  ltl_idle_t  fi;
  logic [7:0] c;

  assign c  = item.text_byte;
  assign fi = from_idle(c);

  // Decode one step
  always_comb begin
    step          = '0;
    step.mode_nxt = mode;
    if (item.end_of_text) begin
      step.mode_nxt = MODE_IDLE;
      unique case (mode)
        MODE_NUMBER: begin
          step.num_res = 2'd1;
          step.res0    = mk(KIND_NUMBER, CH_NUL, 1'b0, 1'b1);
        end
        MODE_SYMBOL: begin
          step.num_res = 2'd1;
          step.res0    = mk(KIND_SYMBOL, CH_NUL, 1'b0, 1'b1);
        end
        MODE_STRING: begin
          step.num_res = 2'd1;
          step.res0    = mk(KIND_BADSTR, CH_NUL, 1'b0, 1'b1);
        end
        MODE_TILDE: begin
          step.num_res = 2'd1;
          step.res0    = mk(KIND_UNQUOTE, CH_TILDE, 1'b1, 1'b1);
        end
        default: step.num_res = 2'd0;
      endcase
    end else begin
      unique case (mode)
        MODE_COMMENT: begin
          if (c == CH_NL) step.mode_nxt = MODE_IDLE;
        end
        MODE_NUMBER: begin
          if (is_num(c)) begin
            step.num_res = 2'd1;
            step.res0    = mk(KIND_NUMBER, c, 1'b1, 1'b0);
          end else begin
            step.num_res  = fi.hit ? 2'd2 : 2'd1;
            step.res0     = mk(KIND_NUMBER, CH_NUL, 1'b0, 1'b1);
            step.res1     = fi.tok;
            step.mode_nxt = fi.mode;
          end
        end
        MODE_SYMBOL: begin
          if (is_space(c) || (c == CH_LBR) || (c == CH_RBR)) begin
            step.num_res  = fi.hit ? 2'd2 : 2'd1;
            step.res0     = mk(KIND_SYMBOL, CH_NUL, 1'b0, 1'b1);
            step.res1     = fi.tok;
            step.mode_nxt = fi.mode;
          end else begin
            step.num_res = 2'd1;
            step.res0    = mk(KIND_SYMBOL, c, 1'b1, 1'b0);
          end
        end
        MODE_STRING: begin
          step.num_res = 2'd1;
          if (c == CH_DQUOTE) begin
            step.res0     = mk(KIND_STRING, CH_NUL, 1'b0, 1'b1);
            step.mode_nxt = MODE_IDLE;
          end else begin
            step.res0 = mk(KIND_STRING, c, 1'b1, 1'b0);
          end
        end
        MODE_TILDE: begin
          if (c == CH_AT) begin
            step.num_res  = 2'd2;
            step.res0     = mk(KIND_SPLICE, CH_TILDE, 1'b1, 1'b0);
            step.res1     = mk(KIND_SPLICE, CH_AT, 1'b1, 1'b1);
            step.mode_nxt = MODE_IDLE;
          end else begin
            step.num_res  = fi.hit ? 2'd2 : 2'd1;
            step.res0     = mk(KIND_UNQUOTE, CH_TILDE, 1'b1, 1'b1);
            step.res1     = fi.tok;
            step.mode_nxt = fi.mode;
          end
        end
        default: begin
          step.num_res  = fi.hit ? 2'd1 : 2'd0;
          step.res0     = fi.tok;
          step.mode_nxt = fi.mode;
        end
      endcase
    end
  end

endmodule

### src/ltl_skid.sv
// Small result queue: takes up to two results per cycle, gives one per cycle while out_ready is high.
module ltl_skid
  import ltl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  ltl_out_t   push_d0,
  input  ltl_out_t   push_d1,
  output logic       room2,
  output logic       out_valid,
  input  logic       out_ready,
  output ltl_out_t   out_data
);

  ltl_out_t          ent_r [SkidDepth];
  logic [SkidAw-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [SkidAw-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [SkidCw-1:0] cnt_r, cnt_nxt;
  logic [SkidAw-1:0] wr_ptr1;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = ent_r[rd_ptr_r];
  assign room2     = (cnt_r <= SkidCw'(SkidDepth - 2));
  assign wr_ptr1   = wr_ptr_r + SkidAw'(1);

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + SkidAw'(push_n);
    rd_ptr_nxt = rd_ptr_r + SkidAw'(pop);
    cnt_nxt    = cnt_r + SkidCw'(push_n) - SkidCw'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) ent_r[wr_ptr_r] <= push_d0;
    if (push_n == 2'd2) ent_r[wr_ptr1]  <= push_d1;
  end

endmodule

### src/lisp_token_lexer_unit.sv
// Top level of the streaming S-expression lexer.
// Takes one text byte (or an end-of-text mark) per transfer and streams out
// tokens as result items of kind, optional byte and last mark. An input
// register feeds the lexer step, whose results land in a four-entry queue
// that drives the output channel. A byte is accepted every cycle as long as
// the output side keeps up; the results of a byte that yields two (a token
// byte closing a number or symbol, a splice, a tilde followed by a token)
// leave one at a time, so the sustained rate is one input per cycle or one
// result per cycle, whichever is lower, set by the single-read port of the
// result queue.
module lisp_token_lexer_unit
  import ltl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ltl_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ltl_out_t out_data
);

  ltl_in_t   item_r;
  logic      item_vld_r, item_vld_nxt;
  ltl_mode_t mode_r, mode_nxt;
  ltl_step_t step;
  logic      room2;
  logic      go;
  logic [1:0] push_n;

  // Process the held item when the queue has room for two results
  assign go       = item_vld_r && room2;
  assign in_ready = !item_vld_r || go;
  assign push_n   = go ? step.num_res : 2'd0;

  always_comb begin
    item_vld_nxt = item_vld_r;
    mode_nxt     = mode_r;
    if (go) begin
      item_vld_nxt = 1'b0;
      mode_nxt     = step.mode_nxt;
    end
    if (in_valid && in_ready) item_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      mode_r     <= MODE_IDLE;
    end else begin
      item_vld_r <= item_vld_nxt;
      mode_r     <= mode_nxt;
    end
  end

  // Hold the input item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
  end

  ltl_core u_core (
    .mode (mode_r),
    .item (item_r),
    .step (step)
  );

  ltl_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_d0   (step.res0),
    .push_d1   (step.res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/tb.sv
// Testbench for the streaming S-expression lexer: directed and random text with flow control.
`timescale 1ns / 100ps

module tb;
  import ltl_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int LongHold      = 100;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ltl_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ltl_out_t out_data;

  // Lexer state as predicted, and the token pieces still owed by the block
  ltl_mode_t lex_mode = MODE_IDLE;
  ltl_out_t  expected_tokens[$];

  int        items_sent = 0;
  int        pieces_checked = 0;
  int        errors = 0;
  int        quiet_cycles = 0;
  bit [9:0]  kinds_seen = '0;
  bit        src_idle_on = 1'b1;
  bit        sink_idle_on = 1'b1;
  int        hold_requests = 0;
  int        holds_served = 0;
  int        hold_left = 0;
  int        stall_left = 0;

  logic [7:0] singles [4] = '{CH_AMP, CH_QUOTE, CH_LBR, CH_RBR};

  lisp_token_lexer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_NUL;
  endfunction

  function automatic bit is_numeric(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT;
  endfunction

  function automatic void push_piece(ltl_kind_t k, logic [7:0] ch, logic v, logic l);
    ltl_out_t p;
    p.token_kind = k;
    p.token_byte = v ? ch : 8'h00;
    p.byte_valid = v;
    p.token_last = l;
    expected_tokens.push_back(p);
  endfunction

  // Start a new token from idle; at most one piece
  function automatic void lex_start(logic [7:0] c);
    lex_mode = MODE_IDLE;
    if (is_blank(c)) return;
    case (c)
      CH_SEMI:   lex_mode = MODE_COMMENT;
      CH_AMP:    push_piece(KIND_AMP, c, 1'b1, 1'b1);
      CH_QUOTE:  push_piece(KIND_QUOTE, c, 1'b1, 1'b1);
      CH_LBR:    push_piece(KIND_OPEN, c, 1'b1, 1'b1);
      CH_RBR:    push_piece(KIND_CLOSE, c, 1'b1, 1'b1);
      CH_TILDE:  lex_mode = MODE_TILDE;
      CH_DQUOTE: lex_mode = MODE_STRING;
      default: begin
        if (is_numeric(c)) begin
          lex_mode = MODE_NUMBER;
          push_piece(KIND_NUMBER, c, 1'b1, 1'b0);
        end else begin
          lex_mode = MODE_SYMBOL;
          push_piece(KIND_SYMBOL, c, 1'b1, 1'b0);
        end
      end
    endcase
  endfunction

  // Advance the predicted lexer by one accepted item
  function automatic void lex_item(logic [7:0] c, logic eot);
    if (eot) begin
      case (lex_mode)
        MODE_NUMBER: push_piece(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
        MODE_SYMBOL: push_piece(KIND_SYMBOL, 8'h00, 1'b0, 1'b1);
        MODE_STRING: push_piece(KIND_BADSTR, 8'h00, 1'b0, 1'b1);
        MODE_TILDE:  push_piece(KIND_UNQUOTE, CH_TILDE, 1'b1, 1'b1);
        default: ;
      endcase
      lex_mode = MODE_IDLE;
      return;
    end
    case (lex_mode)
      MODE_COMMENT: begin
        if (c == CH_NL) lex_mode = MODE_IDLE;
      end
      MODE_NUMBER: begin
        if (is_numeric(c)) begin
          push_piece(KIND_NUMBER, c, 1'b1, 1'b0);
        end else begin
          push_piece(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
          lex_start(c);
        end
      end
      MODE_SYMBOL: begin
        if (is_blank(c) || c == CH_LBR || c == CH_RBR) begin
          push_piece(KIND_SYMBOL, 8'h00, 1'b0, 1'b1);
          lex_start(c);
        end else begin
          push_piece(KIND_SYMBOL, c, 1'b1, 1'b0);
        end
      end
      MODE_STRING: begin
        if (c == CH_DQUOTE) begin
          push_piece(KIND_STRING, 8'h00, 1'b0, 1'b1);
          lex_mode = MODE_IDLE;
        end else begin
          push_piece(KIND_STRING, c, 1'b1, 1'b0);
        end
      end
      MODE_TILDE: begin
        if (c == CH_AT) begin
          push_piece(KIND_SPLICE, CH_TILDE, 1'b1, 1'b0);
          push_piece(KIND_SPLICE, CH_AT, 1'b1, 1'b1);
          lex_mode = MODE_IDLE;
        end else begin
          push_piece(KIND_UNQUOTE, CH_TILDE, 1'b1, 1'b1);
          lex_start(c);
        end
      end
      default: lex_start(c);
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void flag_error(string what, ltl_out_t exp, ltl_out_t got);
    errors++;
    if (errors <= 10) begin
      $display("ERROR %s: expected kind=%0d byte=%02h valid=%0b last=%0b",
               what, exp.token_kind, exp.token_byte, exp.byte_valid, exp.token_last);
      $display("      got kind=%0d byte=%02h valid=%0b last=%0b",
               got.token_kind, got.token_byte, got.byte_valid, got.token_last);
    end
  endfunction

  function automatic void check_piece(ltl_out_t got);
    ltl_out_t exp;
    pieces_checked++;
    if (got.token_kind <= 4'd9) kinds_seen[got.token_kind] = 1'b1;
    if (expected_tokens.size() == 0) begin
      flag_error("unexpected result", '0, got);
      return;
    end
    exp = expected_tokens.pop_front();
    if (got.token_kind !== exp.token_kind || got.token_byte !== exp.token_byte ||
        got.byte_valid !== exp.byte_valid || got.token_last !== exp.token_last)
      flag_error("token piece mismatch", exp, got);
  endfunction

  // Check each result transfer, then pick the next ready: long hold, burst stall or open
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_piece(out_data);
    if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= LongHold - 1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Abort when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_tokens.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Offer one item, optionally after an idle burst, and predict it on transfer
  task automatic send_item(logic [7:0] b, logic eot);
    logic took;
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {b, eot};
    // Sample ready between edges, where it is settled for the coming edge
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    lex_item(b, eot);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Drop valid and wait until the block has delivered everything
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_symbol_byte(bit first);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (is_blank(c) || c == CH_LBR || c == CH_RBR ||
               (first && (is_numeric(c) || c == CH_SEMI || c == CH_AMP ||
                          c == CH_QUOTE || c == CH_TILDE || c == CH_DQUOTE)));
    return c;
  endfunction

  // Send one random fragment: mostly well-formed tokens, some noise
  task automatic send_fragment();
    int pick;
    int len;
    logic [7:0] c;
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1: send_item(singles[2'($urandom_range(0, 3))], 1'b0);
      2: begin
        send_item(CH_TILDE, 1'b0);
        if ($urandom_range(0, 1)) send_item(CH_AT, 1'b0);
      end
      3, 4, 5: begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          c = ($urandom_range(0, 5) == 0) ? CH_DOT : 8'(CH_ZERO + $urandom_range(0, 9));
          send_item(c, 1'b0);
        end
      end
      6, 7, 8: begin
        send_item(pick_symbol_byte(1'b1), 1'b0);
        len = $urandom_range(0, 7);
        repeat (len) send_item(pick_symbol_byte(1'b0), 1'b0);
      end
      9, 10: begin
        send_item(CH_DQUOTE, 1'b0);
        len = $urandom_range(0, 8);
        repeat (len) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_DQUOTE);
          send_item(c, 1'b0);
        end
        if ($urandom_range(0, 7) != 0) send_item(CH_DQUOTE, 1'b0);
      end
      11: begin
        send_item(CH_SEMI, 1'b0);
        len = $urandom_range(0, 6);
        repeat (len) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
          send_item(c, 1'b0);
        end
        send_item(CH_NL, 1'b0);
      end
      12: send_item(CH_SPACE, 1'b0);
      13: send_item(CH_TAB, 1'b0);
      14: send_item(CH_NL, 1'b0);
      15: send_item(CH_NUL, 1'b0);
      16: send_item(8'($urandom_range(0, 255)), 1'b1);
      17, 18: send_item(8'($urandom_range(0, 255)), 1'b0);
      default: send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_single_char_tokens();
    send_text("&'[]");
    send_item(CH_NUL, 1'b0);
    send_text(";\n");
  endtask

  task automatic test_tilde_forms();
    send_text("~@~a");
    send_item(CH_NUL, 1'b1);
    send_text("~");
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_number_and_symbol_ends();
    send_text("9.]");
    send_item(8'hFF, 1'b0);
    send_item(CH_NUL, 1'b0);
  endtask

  task automatic test_strings_and_end_of_text();
    send_text("\"\"\"");
    send_item(8'hFF, 1'b0);
    send_item(CH_NUL, 1'b0);
    send_item(CH_NUL, 1'b1);
    send_text(";");
    send_item(CH_NUL, 1'b1);
    send_item(8'hFF, 1'b1);
  endtask

  // Alternate stretches with and without idling
  task automatic test_random_text(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      src_idle_on = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      repeat (20) send_fragment();
    end
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Hold the output while offering items back to back so the input stalls
  task automatic test_output_hold();
    src_idle_on = 1'b0;
    hold_requests++;
    repeat (48) begin
      if ($urandom_range(0, 1)) send_item(singles[2'($urandom_range(0, 3))], 1'b0);
      else send_item(CH_TILDE, 1'b0);
    end
    src_idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (30) send_fragment();
    pause_until_drained();
    repeat (30) send_fragment();
  endtask

  task automatic test_full_rate();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    repeat (120) send_fragment();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_single_char_tokens();
    test_tilde_forms();
    test_number_and_symbol_ends();
    test_strings_and_end_of_text();
    test_random_text(450);
    test_output_hold();
    test_drain_pause();
    test_random_text(150);
    test_full_rate();

    // Wait out the remaining results, then keep watching for strays
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_tokens.size() != 0) begin
      errors += expected_tokens.size();
      $display("ERROR %0d expected results never arrived", expected_tokens.size());
    end

    $display("Lexed %0d text items into %0d checked token pieces, %0d of 10 kinds seen,",
             items_sent, pieces_checked, $countones(kinds_seen));
    $display("with idle bursts, a long output hold, a drain pause and a full-rate tail;",
             " %0d errors", errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
src/ltl_pkg.sv
src/ltl_core.sv
src/ltl_skid.sv
src/lisp_token_lexer_unit.sv
tb/tb.sv
